// File: rtl/sorted_key_table_defines.svh
// ----------------------------------------------------------------------------
// sorted_key_table_defines.svh
// Assertion macros shared by the checker of the sorted key table.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_DEFINES_SVH
`define SORTED_KEY_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while reset is held.
`define SKT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error("sorted_key_table check failed");

// Next-cycle implication, sampled on aclk, off while reset is held.
`define SKT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error("sorted_key_table check failed");

`endif

// File: rtl/skt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skt_pkg
// Sizes, request codes and beat layouts of the sorted key table.
// ----------------------------------------------------------------------------
package skt_pkg;

    localparam int unsigned DEPTH     = 64;
    localparam int unsigned KEY_W     = 32;
    localparam int unsigned ADDR_W    = 6;
    localparam int unsigned IDX_W     = 7;
    localparam int unsigned STAT_W    = 2;
    localparam int unsigned REQ_W     = 3;
    localparam int unsigned S_DATA_W  = 40;
    localparam int unsigned M_DATA_W  = 24;

    localparam logic [IDX_W-1:0] DEPTH_C = IDX_W'(DEPTH);

    // Request kinds carried on s_tuser.
    localparam logic [REQ_W-1:0] REQ_ADD     = 3'd0;
    localparam logic [REQ_W-1:0] REQ_FIND    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_INS_IDX = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DEL_IDX = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DEL_KEY = 3'd4;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd2;

    // Configuration register indexes (paddr[2]).
    localparam logic REG_KEEP_SORTED = 1'b0;
    localparam logic REG_UNIQUE_KEYS = 1'b1;

    // Result beat layout, lowest bit first.
    localparam int unsigned M_IDX_LO   = 0;
    localparam int unsigned M_FOUND    = 7;
    localparam int unsigned M_STAT_LO  = 8;
    localparam int unsigned M_COUNT_LO = 10;

endpackage

`default_nettype wire

// File: rtl/sorted_key_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_key_table
// Bounded table of up to 64 keys in one memory; adds keep them in ascending order while keep_sorted is set.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive as beats on the s_ channel: the request kind on s_tuser and
// the key and target index on s_tdata. Every request returns exactly one
// result beat on the m_ channel carrying the index, the found flag, a status
// code and the entry count after the request.
// The keys live in a 64 x 32 memory with one write port and one read port
// whose read data is registered and shows in the cycle after the address.
// Searches are a binary search over that memory of at most seven probes,
// each an address step and a compare step; a closing step then reads the
// slot the search ends on and a hit step compares it with the key. Insertions and
// deletions then move each later entry by one slot, one entry per cycle
// through the same memory. The next request can be taken in the cycle after
// the result is handed over. One request is worked on at a time; s_tready
// is high only while the sequencer waits for work. A finished result sits
// in the output register, so the next request is taken while the receiver
// still stalls the previous result. Reset empties the table (the count goes
// to zero, no memory sweep is needed), sets keep_sorted to 1 and unique_keys
// to 0. The APB registers may be written only while no request is in flight.
// ----------------------------------------------------------------------------
module sorted_key_table (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Request channel.
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // s_tdata: key [31:0], target_index [38:32], zero [39]
    input  wire logic [skt_pkg::S_DATA_W-1:0]  s_tdata,
    // s_tuser: req_type [2:0]
    input  wire logic [skt_pkg::REQ_W-1:0]     s_tuser,
    // Result channel.
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // m_tdata: result_index [6:0], found [7], status [9:8],
    //          entry_count [16:10], zero [23:17]
    output logic [skt_pkg::M_DATA_W-1:0]       m_tdata,
    // Configuration port.
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_SEARCH = 8'b0000_0010,
        ST_PROBE  = 8'b0000_0100,
        ST_HIT    = 8'b0000_1000,
        ST_DECIDE = 8'b0001_0000,
        ST_INSERT = 8'b0010_0000,
        ST_DELETE = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } state_t;

    state_t                          state_reg, state_next;
    logic [skt_pkg::REQ_W-1:0]       req_reg, req_next;
    logic [skt_pkg::KEY_W-1:0]       key_reg, key_next;
    logic [skt_pkg::IDX_W-1:0]       tgt_reg, tgt_next;
    logic [skt_pkg::IDX_W-1:0]       lo_reg, lo_next;
    logic [skt_pkg::IDX_W-1:0]       hi_reg, hi_next;
    logic [skt_pkg::IDX_W-1:0]       mid_reg, mid_next;
    logic [skt_pkg::IDX_W-1:0]       idx_reg, idx_next;
    logic                            hit_reg, hit_next;
    logic [skt_pkg::STAT_W-1:0]      status_reg, status_next;
    logic [skt_pkg::IDX_W-1:0]       fill_reg, fill_next;
    logic [skt_pkg::IDX_W-1:0]       ptr_reg, ptr_next;
    logic                            wr_pend_reg, wr_pend_next;
    logic [skt_pkg::ADDR_W-1:0]      wr_addr_reg, wr_addr_next;
    logic                            keep_sorted_reg, keep_sorted_next;
    logic                            unique_keys_reg, unique_keys_next;
    logic                            m_valid_reg, m_valid_next;
    logic [skt_pkg::M_DATA_W-1:0]    m_data_reg, m_data_next;

    // Key memory: one write port, one registered read port.
    logic [skt_pkg::KEY_W-1:0]       key_mem [skt_pkg::DEPTH];
    logic [skt_pkg::KEY_W-1:0]       rd_data_reg;
    logic                            mem_we, mem_re;
    logic [skt_pkg::ADDR_W-1:0]      mem_waddr, mem_raddr;
    logic [skt_pkg::KEY_W-1:0]       mem_wdata;

    logic                            s_accept, cfg_write, table_full;
    logic [skt_pkg::IDX_W-1:0]       mid_calc, ptr_dec, ptr_inc;
    logic [skt_pkg::REQ_W-1:0]       in_req;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign in_req    = s_tuser;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    assign table_full = (fill_reg == skt_pkg::DEPTH_C);
    assign mid_calc   = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign ptr_dec    = ptr_reg - 7'd1;
    assign ptr_inc    = ptr_reg + 7'd1;

    always_comb begin
        case (paddr[2])
            skt_pkg::REG_KEEP_SORTED: prdata = {31'd0, keep_sorted_reg};
            skt_pkg::REG_UNIQUE_KEYS: prdata = {31'd0, unique_keys_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    always_comb begin
        keep_sorted_next = keep_sorted_reg;
        unique_keys_next = unique_keys_reg;
        if (cfg_write) begin
            case (paddr[2])
                skt_pkg::REG_KEEP_SORTED: keep_sorted_next = pwdata[0];
                skt_pkg::REG_UNIQUE_KEYS: unique_keys_next = pwdata[0];
                default: ;
            endcase
        end
    end

    // Request sequencer.
    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        key_next     = key_reg;
        tgt_next     = tgt_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        idx_next     = idx_reg;
        hit_next     = hit_reg;
        status_next  = status_reg;
        fill_next    = fill_reg;
        ptr_next     = ptr_reg;
        wr_pend_next = wr_pend_reg;
        wr_addr_next = wr_addr_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        mem_we       = 1'b0;
        mem_waddr    = wr_addr_reg;
        mem_wdata    = rd_data_reg;
        mem_re       = 1'b0;
        mem_raddr    = mid_calc[skt_pkg::ADDR_W-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    req_next    = in_req;
                    key_next    = s_tdata[31:0];
                    tgt_next    = s_tdata[38:32];
                    lo_next     = '0;
                    hi_next     = fill_reg;
                    hit_next    = 1'b0;
                    status_next = skt_pkg::ST_OK;
                    wr_pend_next = 1'b0;
                    // Searching requests go through the binary search first.
                    if ((in_req == skt_pkg::REQ_ADD && keep_sorted_reg) ||
                        in_req == skt_pkg::REQ_FIND ||
                        in_req == skt_pkg::REQ_DEL_KEY) begin
                        state_next = ST_SEARCH;
                    end else begin
                        state_next = ST_DECIDE;
                        if (in_req == skt_pkg::REQ_ADD) begin
                            idx_next = fill_reg;
                        end else if (in_req == skt_pkg::REQ_INS_IDX ||
                                     in_req == skt_pkg::REQ_DEL_IDX) begin
                            idx_next = s_tdata[38:32];
                        end else begin
                            idx_next = '0;
                        end
                    end
                end
            end
            ST_SEARCH: begin
                if (lo_reg < hi_reg) begin
                    mem_re     = 1'b1;
                    mem_raddr  = mid_calc[skt_pkg::ADDR_W-1:0];
                    mid_next   = mid_calc;
                    state_next = ST_PROBE;
                end else begin
                    idx_next = lo_reg;
                    if (lo_reg < fill_reg) begin
                        mem_re     = 1'b1;
                        mem_raddr  = lo_reg[skt_pkg::ADDR_W-1:0];
                        state_next = ST_HIT;
                    end else begin
                        hit_next   = 1'b0;
                        state_next = ST_DECIDE;
                    end
                end
            end
            ST_PROBE: begin
                if (rd_data_reg < key_reg) begin
                    lo_next = mid_reg + 7'd1;
                end else begin
                    hi_next = mid_reg;
                end
                state_next = ST_SEARCH;
            end
            ST_HIT: begin
                hit_next   = (rd_data_reg == key_reg);
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                state_next = ST_DONE;
                case (req_reg)
                    skt_pkg::REQ_ADD: begin
                        if (keep_sorted_reg && hit_reg && unique_keys_reg) begin
                            state_next = ST_DONE;
                        end else if (table_full) begin
                            status_next = skt_pkg::ST_FULL;
                        end else begin
                            ptr_next   = fill_reg;
                            state_next = ST_INSERT;
                        end
                    end
                    skt_pkg::REQ_INS_IDX: begin
                        if (tgt_reg > fill_reg) begin
                            status_next = skt_pkg::ST_BAD_INDEX;
                        end else if (table_full) begin
                            status_next = skt_pkg::ST_FULL;
                        end else begin
                            ptr_next   = fill_reg;
                            state_next = ST_INSERT;
                        end
                    end
                    skt_pkg::REQ_DEL_IDX: begin
                        if (tgt_reg >= fill_reg) begin
                            status_next = skt_pkg::ST_BAD_INDEX;
                        end else begin
                            ptr_next   = tgt_reg + 7'd1;
                            state_next = ST_DELETE;
                        end
                    end
                    skt_pkg::REQ_DEL_KEY: begin
                        if (hit_reg) begin
                            ptr_next   = idx_reg + 7'd1;
                            state_next = ST_DELETE;
                        end
                    end
                    default: ;
                endcase
            end
            ST_INSERT: begin
                // Move entries up one slot, from the top down to the gap.
                // A read issued in one cycle is written one slot higher in
                // the next, so the read and write never touch the same entry.
                if (wr_pend_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = wr_addr_reg;
                    mem_wdata = rd_data_reg;
                end
                if (ptr_reg > idx_reg) begin
                    mem_re       = 1'b1;
                    mem_raddr    = ptr_dec[skt_pkg::ADDR_W-1:0];
                    wr_pend_next = 1'b1;
                    wr_addr_next = ptr_reg[skt_pkg::ADDR_W-1:0];
                    ptr_next     = ptr_dec;
                end else begin
                    wr_pend_next = 1'b0;
                    if (!wr_pend_reg) begin
                        mem_we     = 1'b1;
                        mem_waddr  = idx_reg[skt_pkg::ADDR_W-1:0];
                        mem_wdata  = key_reg;
                        fill_next  = fill_reg + 7'd1;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DELETE: begin
                // Move entries down one slot, from just above the hole upward.
                if (wr_pend_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = wr_addr_reg;
                    mem_wdata = rd_data_reg;
                end
                if (ptr_reg < fill_reg) begin
                    mem_re       = 1'b1;
                    mem_raddr    = ptr_reg[skt_pkg::ADDR_W-1:0];
                    wr_pend_next = 1'b1;
                    wr_addr_next = ptr_dec[skt_pkg::ADDR_W-1:0];
                    ptr_next     = ptr_inc;
                end else begin
                    wr_pend_next = 1'b0;
                    if (!wr_pend_reg) begin
                        fill_next  = fill_reg - 7'd1;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                // Hand the result to the output register once it is free.
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {7'd0, fill_reg, status_reg, hit_reg, idx_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            key_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= key_mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            fill_reg        <= '0;
            wr_pend_reg     <= 1'b0;
            keep_sorted_reg <= 1'b1;
            unique_keys_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            fill_reg        <= fill_next;
            wr_pend_reg     <= wr_pend_next;
            keep_sorted_reg <= keep_sorted_next;
            unique_keys_reg <= unique_keys_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_next_hold: begin
            req_reg     <= req_next;
            key_reg     <= key_next;
            tgt_reg     <= tgt_next;
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
            mid_reg     <= mid_next;
            idx_reg     <= idx_next;
            hit_reg     <= hit_next;
            status_reg  <= status_next;
            ptr_reg     <= ptr_next;
            wr_addr_reg <= wr_addr_next;
            m_data_reg  <= m_data_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/skt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skt_checker
// Port-level checks of the sorted key table, bound to its top level.
// ----------------------------------------------------------------------------
`include "sorted_key_table_defines.svh"

module skt_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [skt_pkg::M_DATA_W-1:0]  m_tdata
);

    logic [skt_pkg::IDX_W-1:0]  res_idx, res_count;
    logic                       res_found;
    logic [skt_pkg::STAT_W-1:0] res_status;

    assign res_idx    = m_tdata[skt_pkg::M_IDX_LO +: skt_pkg::IDX_W];
    assign res_found  = m_tdata[skt_pkg::M_FOUND];
    assign res_status = m_tdata[skt_pkg::M_STAT_LO +: skt_pkg::STAT_W];
    assign res_count  = m_tdata[skt_pkg::M_COUNT_LO +: skt_pkg::IDX_W];

    // A stalled result beat stays put.
    `SKT_ASSERT_NEXT(a_result_held, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Requests are worked one at a time: no accept on the cycle after one.
    `SKT_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)

    // A full-table refusal is only reported when the table really is full.
    `SKT_ASSERT_SAME(a_full_count, m_tvalid && res_status == skt_pkg::ST_FULL,
                     res_count == skt_pkg::DEPTH_C)

    // A hit index is at most the entry count and never comes with a bad index.
    `SKT_ASSERT_SAME(a_hit_in_range, m_tvalid && res_found,
                     res_idx <= res_count && res_status != skt_pkg::ST_BAD_INDEX)

endmodule

bind sorted_key_table skt_checker u_skt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
